// ===== design/mlpsgd_pkg.sv =====
// Shared constants, codes and helper functions for the MLP training engine.
package mlpsgd_pkg;

  localparam int HIDDEN_ONE   = 3;
  localparam int HIDDEN_TWO   = 4;
  localparam int HIDDEN_THREE = 3;
  localparam int LAYER_COUNT  = 5;
  localparam int FRAC_BITS    = 24;
  localparam int LR_FRAC      = 24;

  localparam int N_ALL   = 2 + HIDDEN_ONE + HIDDEN_TWO + HIDDEN_THREE + 1;
  localparam int N_W     = 2 * HIDDEN_ONE + HIDDEN_ONE * HIDDEN_TWO +
                           HIDDEN_TWO * HIDDEN_THREE + HIDDEN_THREE;
  localparam int N_B     = HIDDEN_ONE + HIDDEN_TWO + HIDDEN_THREE + 1;
  localparam int N_PARAM = N_W + N_B;
  localparam int N_ACT   = N_ALL - 1;
  localparam int N_DEL   = N_ALL - 2;

  localparam int PAR_AW = $clog2(N_PARAM);
  localparam int ACT_AW = $clog2(N_ACT);
  localparam int DEL_AW = $clog2(N_DEL);
  localparam int CNT_W  = 5;
  localparam int LAY_W  = 3;
  localparam int ACC_W  = 40;

  localparam int TAB_UP   = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int TAB_DN   = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 1;
  localparam int TAB_LAST = 16;

  localparam logic signed [32:0] Q_ONE    = 33'(1) << FRAC_BITS;
  localparam logic [26:0]        LR_RESET = 27'd16777216;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_INFER = 2'd1,
    FN_TRAIN = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  function automatic logic [CNT_W-1:0] lay_sz(input logic [LAY_W-1:0] l);
    logic [CNT_W-1:0] r;
    unique case (l)
      3'd0:    r = CNT_W'(2);
      3'd1:    r = CNT_W'(HIDDEN_ONE);
      3'd2:    r = CNT_W'(HIDDEN_TWO);
      3'd3:    r = CNT_W'(HIDDEN_THREE);
      default: r = CNT_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] act_off(input logic [LAY_W-1:0] l);
    logic [7:0] r;
    unique case (l)
      3'd0:    r = 8'(0);
      3'd1:    r = 8'(2);
      3'd2:    r = 8'(2 + HIDDEN_ONE);
      3'd3:    r = 8'(2 + HIDDEN_ONE + HIDDEN_TWO);
      default: r = 8'(2 + HIDDEN_ONE + HIDDEN_TWO + HIDDEN_THREE);
    endcase
    return r;
  endfunction

  function automatic logic [PAR_AW-1:0] w_off(input logic [LAY_W-1:0] l);
    logic [PAR_AW-1:0] r;
    unique case (l)
      3'd0:    r = PAR_AW'(0);
      3'd1:    r = PAR_AW'(2 * HIDDEN_ONE);
      3'd2:    r = PAR_AW'(2 * HIDDEN_ONE + HIDDEN_ONE * HIDDEN_TWO);
      default: r = PAR_AW'(2 * HIDDEN_ONE + HIDDEN_ONE * HIDDEN_TWO +
                            HIDDEN_TWO * HIDDEN_THREE);
    endcase
    return r;
  endfunction

  // Sigmoid samples at x = 0, 0.5, ..., 8 with 24 fraction bits, scaled to FRAC_BITS.
  function automatic logic [31:0] sig_tab(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:    t = 32'd8388608;
      5'd1:    t = 32'd10443135;
      5'd2:    t = 32'd12265128;
      5'd3:    t = 32'd13716624;
      5'd4:    t = 32'd14777323;
      5'd5:    t = 32'd15504527;
      5'd6:    t = 32'd15981542;
      5'd7:    t = 32'd16285438;
      5'd8:    t = 32'd16475457;
      5'd9:    t = 32'd16592886;
      5'd10:   t = 32'd16664929;
      5'd11:   t = 32'd16708930;
      5'd12:   t = 32'd16735732;
      5'd13:   t = 32'd16752030;
      5'd14:   t = 32'd16761931;
      5'd15:   t = 32'd16767942;
      default: t = 32'd16771590;
    endcase
    if (FRAC_BITS >= 24) begin
      return t << TAB_UP;
    end
    return (t + (32'd1 << (TAB_DN - 1))) >> TAB_DN;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round half up at bit s, floor, then saturate.
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p, input int s);
    logic signed [65:0] t;
    t = p + (66'sd1 <<< (s - 1));
    t = t >>> s;
    return sat32(t);
  endfunction

  function automatic logic signed [32:0] sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

endpackage

// ===== design/mlp_sgd_train_step_core.sv =====
// MLP training engine: sequencer, shared multiplier, parameter memory and caches.
//
// One request at a time: start is taken while busy is low, and exactly one result
// appears later on out_valid for a single cycle; the receiver cannot stall it.
// A parameter write returns its result in the next cycle; a read passes through the
// registered memory output and then the result register. Inference and training
// are paced by the single shared 33x33 multiplier, which does every product
// in turn, and by the one read port of the parameter memory with its registered
// output; each weight update is a read, two multiplies and a write back.
// The learning rate may be written on the cfg channel only while the block is idle.
module mlp_sgd_train_step_core
  import mlpsgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_param_index,
  input  logic signed [31:0] in_param_value,
  input  logic signed [31:0] in_feature_a,
  input  logic signed [31:0] in_feature_b,
  input  logic signed [31:0] in_target,
  output logic               out_valid,
  output logic signed [31:0] out_net_output,
  output logic [30:0]        out_half_sq_error,
  output logic signed [31:0] out_read_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [26:0]        cfg_data
);

  typedef enum logic [24:0] {
    ST_IDLE   = 25'h0000001,
    ST_RD     = 25'h0000002,
    ST_F_BIAS = 25'h0000004,
    ST_F_BLD  = 25'h0000008,
    ST_F_MUL  = 25'h0000010,
    ST_F_ACC  = 25'h0000020,
    ST_F_SIG1 = 25'h0000040,
    ST_F_SIG2 = 25'h0000080,
    ST_F_NET  = 25'h0000100,
    ST_E_MUL  = 25'h0000200,
    ST_E_DONE = 25'h0000400,
    ST_B_ISS  = 25'h0000800,
    ST_B_MUL  = 25'h0001000,
    ST_B_ACC  = 25'h0002000,
    ST_B_DS   = 25'h0004000,
    ST_B_DS2  = 25'h0008000,
    ST_B_DM   = 25'h0010000,
    ST_B_DW   = 25'h0020000,
    ST_U_ISS  = 25'h0040000,
    ST_U_G    = 25'h0080000,
    ST_U_L    = 25'h0100000,
    ST_U_LM   = 25'h0200000,
    ST_U_WB   = 25'h0400000,
    ST_U_BISS = 25'h0800000,
    ST_U_BG   = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] param_mem [N_PARAM];
  logic signed [31:0] rdata_r;
  logic signed [31:0] activ_r [N_ACT];
  logic signed [31:0] delta_r [N_DEL];

  logic [1:0]               func_r;
  logic signed [31:0]       tgt_r;
  logic                     idx_ok_r;
  logic [LAY_W-1:0]         l_r;
  logic [CNT_W-1:0]         i_r, j_r;
  logic [PAR_AW-1:0]        wptr_r, bptr_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [65:0]       p_r;
  logic signed [31:0]       ds_r, g_r, wq_r, net_r;
  logic [31:0]              lo_r;
  logic                     neg_r, bias_r;
  logic [30:0]              err_r;
  logic [26:0]              lr_r;
  logic                     out_valid_r;
  logic signed [31:0]       out_net_r, out_read_r;
  logic [30:0]              out_err_r;

  logic [LAY_W-1:0]   l_dn, l_up;
  logic               fw_last_j, cur_last_i, fw_out, bw_last_j, bw_done;
  logic               up_last_j, up_last_i, up_done, idx_ok, accept;
  logic [ACT_AW-1:0]  act_ra, act_wa;
  logic [DEL_AW-1:0]  del_ra, del_wa;
  logic signed [31:0] act_rd, del_rd, zc, diff, upd, sig_s, rs_q;
  logic [PAR_AW-1:0]  rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;
  logic signed [32:0] mul_a, mul_b, mag;
  logic [32:0]        sidx;
  logic               big;
  logic [4:0]         tidx;
  logic [31:0]        sd;
  logic signed [65:0] sq;
  logic [30:0]        err_v;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_net_output    = out_net_r;
  assign out_half_sq_error = out_err_r;
  assign out_read_word     = out_read_r;

  assign l_dn = l_r - LAY_W'(1);
  assign l_up = l_r + LAY_W'(1);

  assign fw_last_j  = (j_r == lay_sz(l_dn) - CNT_W'(1));
  assign cur_last_i = (i_r == lay_sz(l_r) - CNT_W'(1));
  assign fw_out     = (l_r == LAY_W'(LAYER_COUNT - 1));
  assign bw_last_j  = (j_r == lay_sz(l_up) - CNT_W'(1));
  assign bw_done    = (l_r == LAY_W'(1));
  assign up_last_j  = (j_r == lay_sz(l_r) - CNT_W'(1));
  assign up_last_i  = (i_r == lay_sz(l_up) - CNT_W'(1));
  assign up_done    = (l_r == LAY_W'(LAYER_COUNT - 2));
  assign idx_ok     = (int'(in_param_index) < N_PARAM);

  // Cache read and write addresses.
  always_comb begin
    case (state_r)
      ST_F_MUL: act_ra = ACT_AW'(act_off(l_dn) + 8'(j_r));
      ST_B_DS:  act_ra = ACT_AW'(act_off(l_r) + 8'(i_r));
      default:  act_ra = ACT_AW'(act_off(l_r) + 8'(j_r));
    endcase
    case (state_r)
      ST_B_MUL: del_ra = DEL_AW'(act_off(l_up) + 8'(j_r) - 8'd2);
      default:  del_ra = DEL_AW'(act_off(l_up) + 8'(i_r) - 8'd2);
    endcase
    act_wa = ACT_AW'(act_off(l_r) + 8'(i_r));
    del_wa = DEL_AW'(act_off(l_r) + 8'(i_r) - 8'd2);
  end

  assign act_rd = activ_r[act_ra];
  assign del_rd = delta_r[del_ra];

  assign zc   = sat32(66'(acc_r));
  assign diff = sat32(66'(sx(net_r) - sx(tgt_r)));
  assign rs_q = rnd_sat(p_r, FRAC_BITS);
  assign upd  = sat32(66'(sx(wq_r) - sx(rnd_sat(p_r, LR_FRAC))));

  // Sigmoid table lookup and interpolation operands.
  always_comb begin
    mag  = zc[31] ? -sx(zc) : sx(zc);
    sidx = 33'(mag) >> (FRAC_BITS - 1);
    big  = (sidx >= 33'(TAB_LAST));
    tidx = big ? 5'(TAB_LAST) : sidx[4:0];
    sd   = big ? 32'd0 : sig_tab(tidx + 5'd1) - sig_tab(tidx);
  end

  always_comb begin
    sig_s = $signed(lo_r + p_r[FRAC_BITS-1 +: 32]);
    if (neg_r) begin
      sig_s = Q_ONE[31:0] - sig_s;
    end
  end

  always_comb begin
    sq    = (p_r + (66'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    err_v = (sq > 66'sd2147483647) ? 31'h7fffffff : sq[30:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      ST_F_MUL: begin
        mul_a = sx(rdata_r);
        mul_b = sx(act_rd);
      end
      ST_F_SIG1: begin
        mul_a = $signed({1'b0, sd});
        mul_b = $signed(33'(mag[FRAC_BITS-2:0]));
      end
      ST_E_MUL: begin
        mul_a = sx(diff);
        mul_b = sx(diff);
      end
      ST_B_MUL: begin
        mul_a = sx(rdata_r);
        mul_b = sx(del_rd);
      end
      ST_B_DS: begin
        mul_a = sx(act_rd);
        mul_b = Q_ONE - sx(act_rd);
      end
      ST_B_DM: begin
        mul_a = sx(zc);
        mul_b = sx(ds_r);
      end
      ST_U_G: begin
        mul_a = sx(del_rd);
        mul_b = sx(act_rd);
      end
      ST_U_LM: begin
        mul_a = $signed({6'd0, lr_r});
        mul_b = sx(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Parameter memory ports.
  always_comb begin
    case (state_r)
      ST_IDLE:              rd_addr = PAR_AW'(in_param_index);
      ST_F_BIAS, ST_U_BISS: rd_addr = bptr_r;
      default:              rd_addr = wptr_r;
    endcase
    wr_en   = 1'b0;
    wr_addr = bias_r ? bptr_r : wptr_r;
    wr_data = upd;
    if (state_r == ST_U_WB) begin
      wr_en = 1'b1;
    end else if (accept && in_func == FN_WRITE && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = PAR_AW'(in_param_index);
      wr_data = in_param_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      param_mem[wr_addr] <= wr_data;
    end
    rdata_r <= param_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_func)
            FN_WRITE: state_nxt = ST_IDLE;
            FN_READ:  state_nxt = ST_RD;
            default:  state_nxt = ST_F_BIAS;
          endcase
        end
      end
      ST_RD:     state_nxt = ST_IDLE;
      ST_F_BIAS: state_nxt = ST_F_BLD;
      ST_F_BLD:  state_nxt = ST_F_MUL;
      ST_F_MUL:  state_nxt = ST_F_ACC;
      ST_F_ACC: begin
        if (!fw_last_j) begin
          state_nxt = ST_F_MUL;
        end else begin
          state_nxt = fw_out ? ST_F_NET : ST_F_SIG1;
        end
      end
      ST_F_SIG1: state_nxt = ST_F_SIG2;
      ST_F_SIG2: state_nxt = ST_F_BIAS;
      ST_F_NET:  state_nxt = ST_E_MUL;
      ST_E_MUL:  state_nxt = ST_E_DONE;
      ST_E_DONE: state_nxt = (func_r == FN_INFER) ? ST_IDLE : ST_B_ISS;
      ST_B_ISS:  state_nxt = ST_B_MUL;
      ST_B_MUL:  state_nxt = ST_B_ACC;
      ST_B_ACC:  state_nxt = bw_last_j ? ST_B_DS : ST_B_MUL;
      ST_B_DS:   state_nxt = ST_B_DS2;
      ST_B_DS2:  state_nxt = ST_B_DM;
      ST_B_DM:   state_nxt = ST_B_DW;
      ST_B_DW:   state_nxt = (cur_last_i && bw_done) ? ST_U_ISS : ST_B_ISS;
      ST_U_ISS:  state_nxt = ST_U_G;
      ST_U_G:    state_nxt = ST_U_L;
      ST_U_L:    state_nxt = ST_U_LM;
      ST_U_LM:   state_nxt = ST_U_WB;
      ST_U_BISS: state_nxt = ST_U_BG;
      ST_U_BG:   state_nxt = ST_U_LM;
      ST_U_WB: begin
        if (!bias_r) begin
          state_nxt = up_last_j ? ST_U_BISS : ST_U_ISS;
        end else begin
          state_nxt = (up_last_i && up_done) ? ST_IDLE : ST_U_ISS;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control state, caches and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lr_r        <= LR_RESET;
      for (int k = 0; k < N_ACT; k++) begin
        activ_r[k] <= '0;
      end
      for (int k = 0; k < N_DEL; k++) begin
        delta_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        lr_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (in_func == FN_WRITE) begin
              out_valid_r <= 1'b1;
            end else if (in_func != FN_READ) begin
              activ_r[0] <= in_feature_a;
              activ_r[1] <= in_feature_b;
            end
          end
        end
        ST_RD:     out_valid_r <= 1'b1;
        ST_F_SIG2: activ_r[act_wa] <= sig_s;
        ST_E_DONE: begin
          if (func_r == FN_INFER) begin
            out_valid_r <= 1'b1;
          end else begin
            delta_r[N_DEL-1] <= diff;
          end
        end
        ST_B_DW:   delta_r[del_wa] <= rs_q;
        ST_U_WB: begin
          if (bias_r && up_last_i && up_done) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, counters and result payload.
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        func_r    <= in_func;
        tgt_r     <= in_target;
        idx_ok_r  <= idx_ok;
        l_r       <= LAY_W'(1);
        i_r       <= '0;
        j_r       <= '0;
        wptr_r    <= '0;
        bptr_r    <= PAR_AW'(N_W);
        bias_r    <= 1'b0;
        out_net_r <= '0;
        out_err_r <= '0;
        out_read_r <= '0;
      end
      ST_RD: begin
        out_read_r <= idx_ok_r ? rdata_r : 32'sd0;
      end
      ST_F_BLD:  acc_r <= ACC_W'(rdata_r);
      ST_F_MUL:  wptr_r <= wptr_r + PAR_AW'(1);
      ST_F_ACC: begin
        acc_r <= acc_r + ACC_W'(rs_q);
        j_r   <= fw_last_j ? '0 : j_r + CNT_W'(1);
      end
      ST_F_SIG1: begin
        lo_r  <= sig_tab(tidx);
        neg_r <= zc[31];
      end
      ST_F_SIG2: begin
        bptr_r <= bptr_r + PAR_AW'(1);
        if (cur_last_i) begin
          l_r <= l_up;
          i_r <= '0;
        end else begin
          i_r <= i_r + CNT_W'(1);
        end
      end
      ST_F_NET:  net_r <= zc;
      ST_E_DONE: begin
        err_r     <= err_v;
        out_net_r <= net_r;
        out_err_r <= err_v;
        l_r       <= LAY_W'(LAYER_COUNT - 2);
        i_r       <= '0;
        j_r       <= '0;
        wptr_r    <= w_off(LAY_W'(LAYER_COUNT - 2));
      end
      ST_B_ISS:  acc_r <= '0;
      ST_B_MUL:  wptr_r <= wptr_r + PAR_AW'(lay_sz(l_r));
      ST_B_ACC: begin
        acc_r <= acc_r + ACC_W'(rs_q);
        j_r   <= bw_last_j ? '0 : j_r + CNT_W'(1);
      end
      ST_B_DS2:  ds_r <= rs_q;
      ST_B_DW: begin
        if (cur_last_i && bw_done) begin
          // Backward pass done: the update walks all parameters, each unit's weights in storage order, then its bias.
          l_r    <= '0;
          i_r    <= '0;
          j_r    <= '0;
          wptr_r <= '0;
          bptr_r <= PAR_AW'(N_W);
        end else if (cur_last_i) begin
          l_r    <= l_dn;
          i_r    <= '0;
          wptr_r <= w_off(l_dn);
        end else begin
          i_r    <= i_r + CNT_W'(1);
          wptr_r <= w_off(l_r) + PAR_AW'(i_r) + PAR_AW'(1);
        end
      end
      ST_U_G: begin
        wq_r   <= rdata_r;
        bias_r <= 1'b0;
      end
      ST_U_L:    g_r <= rs_q;
      ST_U_BG: begin
        wq_r   <= rdata_r;
        g_r    <= del_rd;
        bias_r <= 1'b1;
      end
      ST_U_WB: begin
        if (!bias_r) begin
          wptr_r <= wptr_r + PAR_AW'(1);
          j_r    <= up_last_j ? '0 : j_r + CNT_W'(1);
        end else begin
          bptr_r <= bptr_r + PAR_AW'(1);
          if (up_last_i) begin
            l_r <= l_up;
            i_r <= '0;
          end else begin
            i_r <= i_r + CNT_W'(1);
          end
        end
        out_net_r  <= net_r;
        out_err_r  <= err_r;
        out_read_r <= '0;
      end
      default: ;
    endcase
  end

  // A result only follows an accepted request or the end of a sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ST_IDLE || start))
    else $error("result strobe without a request in flight");

  // Read results carry no network output or error.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_read_word != 32'sd0) |->
      (out_net_output == 32'sd0 && out_half_sq_error == 31'd0))
    else $error("read result mixed with network output");

  // The parameter memory is written only by a write request or an update write-back.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_U_WB || (state_r == ST_IDLE && start && in_func == FN_WRITE)))
    else $error("unexpected parameter memory write");

  // The forward source counter stays inside the previous layer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_ACC) |-> (j_r < lay_sz(l_dn)))
    else $error("forward source counter out of range");

  // Every parameter write-back comes straight from a learning-rate multiply.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_U_WB) |-> $past(state_r == ST_U_LM))
    else $error("write-back without learning-rate product");

endmodule
